/* rtl/core/ctp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int ITERATIONS_DEF = 16;
	localparam int ATAN_TABLE_LEN = 24;

	// coordinates enter the rotator scaled by 2^20
	localparam int GUARD_SHIFT   = 20;
	// headroom for rotator gain and the left half-plane turn
	localparam int CORDIC_MARGIN = 3;

	// angle accumulator: degrees in q.16
	localparam int ZW           = 26;
	localparam int ANGLE_WIDTH  = 16;
	localparam int Z_DEG_90     = 90 * 65536;
	localparam int ROUND_HALF   = 256;
	localparam int ROUND_SHIFT  = 9;
	localparam int ANG_DEG_180  = 23040;
	localparam int ANG_DEG_90   = 11520;

	typedef enum logic [2:0] {
		SEL_CORDIC,
		SEL_ZERO,
		SEL_POS180,
		SEL_POS90,
		SEL_NEG90
	} ang_sel_t;

	typedef struct packed {
		logic     valid;
		ang_sel_t sel;
	} ctp_ctl_t;

	// atan(2^-i) in degrees, q.16, rounded to nearest
	function automatic logic signed [ZW-1:0] ctp_atan(input logic [4:0] idx);
		logic signed [ZW-1:0] v;
		begin
			case (idx)
				5'd0:    v = ZW'(2949120);
				5'd1:    v = ZW'(1740967);
				5'd2:    v = ZW'(919879);
				5'd3:    v = ZW'(466945);
				5'd4:    v = ZW'(234379);
				5'd5:    v = ZW'(117304);
				5'd6:    v = ZW'(58666);
				5'd7:    v = ZW'(29335);
				5'd8:    v = ZW'(14668);
				5'd9:    v = ZW'(7334);
				5'd10:   v = ZW'(3667);
				5'd11:   v = ZW'(1833);
				5'd12:   v = ZW'(917);
				5'd13:   v = ZW'(458);
				5'd14:   v = ZW'(229);
				5'd15:   v = ZW'(115);
				5'd16:   v = ZW'(57);
				5'd17:   v = ZW'(29);
				5'd18:   v = ZW'(14);
				5'd19:   v = ZW'(7);
				5'd20:   v = ZW'(4);
				5'd21:   v = ZW'(2);
				5'd22:   v = ZW'(1);
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

`default_nettype wire

/* rtl/core/ctp_prep.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctp_prep import ctp_pkg::*; #(
	parameter int W  = DATA_WIDTH_DEF,
	parameter int CW = DATA_WIDTH_DEF + GUARD_SHIFT + CORDIC_MARGIN,
	parameter int RW = 2 * DATA_WIDTH_DEF + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic signed [W-1:0]  x_coord,
	input  wire logic signed [W-1:0]  y_coord,
	output ctp_ctl_t                  ctl,
	output logic signed [CW-1:0]      cx,
	output logic signed [CW-1:0]      cy,
	output logic signed [ZW-1:0]      z,
	output logic        [RW-1:0]      rem
);

	logic signed [CW-1:0] xg, yg, cx_nx, cy_nx;
	logic signed [ZW-1:0] z_nx;
	ang_sel_t             sel_nx;

	ctp_ctl_t             ctl_s1, ctl_s2;
	logic signed [2*W-1:0] sq_x_s1, sq_y_s1;
	logic signed [CW-1:0] cx_s1, cy_s1, cx_s2, cy_s2;
	logic signed [ZW-1:0] z_s1, z_s2;
	logic        [RW-1:0] sum_s2;

	always_comb begin
		xg = CW'(x_coord) <<< GUARD_SHIFT;
		yg = CW'(y_coord) <<< GUARD_SHIFT;
		cx_nx = xg;
		cy_nx = yg;
		z_nx = '0;
		// left half-plane: turn by a quarter first
		if (x_coord[W-1]) begin
			if (!y_coord[W-1]) begin
				cx_nx = yg;
				cy_nx = -xg;
				z_nx = ZW'(Z_DEG_90);
			end else begin
				cx_nx = -yg;
				cy_nx = xg;
				z_nx = -ZW'(Z_DEG_90);
			end
		end
		if (y_coord == '0)
			sel_nx = x_coord[W-1] ? SEL_POS180 : SEL_ZERO;
		else if (x_coord == '0)
			sel_nx = y_coord[W-1] ? SEL_NEG90 : SEL_POS90;
		else
			sel_nx = SEL_CORDIC;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= '{valid: in_valid, sel: sel_nx};
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_x_s1 <= (2*W)'(x_coord) * (2*W)'(x_coord);
			sq_y_s1 <= (2*W)'(y_coord) * (2*W)'(y_coord);
			cx_s1 <= cx_nx;
			cy_s1 <= cy_nx;
			z_s1 <= z_nx;
			sum_s2 <= RW'($unsigned(sq_x_s1)) + RW'($unsigned(sq_y_s1));
			cx_s2 <= cx_s1;
			cy_s2 <= cy_s1;
			z_s2 <= z_s1;
		end
	end

	assign ctl = ctl_s2;
	assign cx  = cx_s2;
	assign cy  = cy_s2;
	assign z   = z_s2;
	assign rem = sum_s2;

endmodule

`default_nettype wire

/* rtl/core/ctp_cordic_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctp_cordic_cell import ctp_pkg::*; #(
	parameter int CW    = DATA_WIDTH_DEF + GUARD_SHIFT + CORDIC_MARGIN,
	parameter int SHIFT = 0,
	parameter int ITERS = ITERATIONS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire ctp_ctl_t             ctl_in,
	input  wire logic signed [CW-1:0] cx_in,
	input  wire logic signed [CW-1:0] cy_in,
	input  wire logic signed [ZW-1:0] z_in,
	output ctp_ctl_t                  ctl_out,
	output logic signed [CW-1:0]      cx_out,
	output logic signed [CW-1:0]      cy_out,
	output logic signed [ZW-1:0]      z_out
);

	logic signed [CW-1:0] cx_nx, cy_nx;
	logic signed [ZW-1:0] z_nx;
	ctp_ctl_t             ctl_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] z_q;

	generate
		if (SHIFT < ITERS && SHIFT < ATAN_TABLE_LEN) begin : g_rot
			localparam logic signed [ZW-1:0] ATAN_STEP = ctp_atan(5'(SHIFT));
			logic signed [CW-1:0] dx, dy;
			always_comb begin
				dx = cy_in >>> SHIFT;
				dy = cx_in >>> SHIFT;
				// drive y toward zero
				if (!cy_in[CW-1]) begin
					cx_nx = cx_in + dx;
					cy_nx = cy_in - dy;
					z_nx = z_in + ATAN_STEP;
				end else begin
					cx_nx = cx_in - dx;
					cy_nx = cy_in + dy;
					z_nx = z_in - ATAN_STEP;
				end
			end
		end else begin : g_pass
			always_comb begin
				cx_nx = cx_in;
				cy_nx = cy_in;
				z_nx = z_in;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_q <= cx_nx;
			cy_q <= cy_nx;
			z_q <= z_nx;
		end
	end

	assign ctl_out = ctl_q;
	assign cx_out  = cx_q;
	assign cy_out  = cy_q;
	assign z_out   = z_q;

endmodule

`default_nettype wire

/* rtl/core/ctp_sqrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module ctp_sqrt_cell import ctp_pkg::*; #(
	parameter int W   = DATA_WIDTH_DEF,
	parameter int RW  = 2 * DATA_WIDTH_DEF + 1,
	parameter int BIT = DATA_WIDTH_DEF - 1
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [W-1:0]  q_in,
	input  wire logic [RW-1:0] rem_in,
	output logic      [W-1:0]  q_out,
	output logic      [RW-1:0] rem_out
);

	logic [W-1:0]  q_nx, q_q;
	logic [RW-1:0] rem_nx, rem_q;

	generate
		if (BIT >= 0) begin : g_digit
			logic [RW-1:0] trial;
			always_comb begin
				// (q + 2^b)^2 - q^2
				trial = (RW'(q_in) << (BIT + 1)) + (RW'(1) << (2 * BIT));
				if (rem_in >= trial) begin
					rem_nx = rem_in - trial;
					q_nx = q_in | (W'(1) << BIT);
				end else begin
					rem_nx = rem_in;
					q_nx = q_in;
				end
			end
		end else begin : g_pass
			always_comb begin
				rem_nx = rem_in;
				q_nx = q_in;
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= q_nx;
			rem_q <= rem_nx;
		end
	end

	assign q_out   = q_q;
	assign rem_out = rem_q;

endmodule

`default_nettype wire

/* rtl/core/cartesian_to_polar_unit.sv */
// throughput: one item per cycle unless the output stalls; one register stage
// per cordic rotation and per square root bit, the longer of the two sets the
// pipeline depth
// an input skid register keeps s_axis_tready registered under output stall
// reset clears the valid and angle select fields only; datapath registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_polar_unit import ctp_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int ITERATIONS = ITERATIONS_DEF,
	localparam int IN_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((DATA_WIDTH + ANGLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,  // x_coord, y_coord
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic      [OUT_W-1:0] m_axis_tdata   // magnitude, angle_degrees
);

	localparam int CW = DATA_WIDTH + GUARD_SHIFT + CORDIC_MARGIN;
	localparam int RW = 2 * DATA_WIDTH + 1;
	localparam int NI = (ITERATIONS < ATAN_TABLE_LEN) ? ITERATIONS : ATAN_TABLE_LEN;
	localparam int D  = (NI > DATA_WIDTH) ? NI : DATA_WIDTH;

	logic                         en;
	logic                         skid_valid_q;
	logic [2*DATA_WIDTH-1:0]      skid_q;
	logic                         pipe_valid;
	logic [2*DATA_WIDTH-1:0]      pipe_data;

	ctp_ctl_t                     ctl_c [0:D];
	logic signed [CW-1:0]         cx_c  [0:D];
	logic signed [CW-1:0]         cy_c  [0:D];
	logic signed [ZW-1:0]         z_c   [0:D];
	logic        [DATA_WIDTH-1:0] q_c   [0:D];
	logic        [RW-1:0]         rem_c [0:D];

	logic signed [ZW-1:0]         z_rnd;
	logic signed [ANGLE_WIDTH-1:0] ang_cordic, ang_nx;
	logic        [DATA_WIDTH-1:0] mag_nx;

	logic                         out_valid_q;
	logic        [DATA_WIDTH-1:0] mag_q;
	logic signed [ANGLE_WIDTH-1:0] ang_q;

	assign en = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !skid_valid_q;

	// skid holds an item taken while the pipeline is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (en) begin
			skid_valid_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && s_axis_tvalid && s_axis_tready)
			skid_q <= s_axis_tdata[2*DATA_WIDTH-1:0];
	end

	assign pipe_valid = skid_valid_q || (s_axis_tvalid && s_axis_tready);
	assign pipe_data  = skid_valid_q ? skid_q : s_axis_tdata[2*DATA_WIDTH-1:0];

	ctp_prep #(
		.W  (DATA_WIDTH),
		.CW (CW),
		.RW (RW)
	) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pipe_valid),
		.x_coord  ($signed(pipe_data[DATA_WIDTH-1:0])),
		.y_coord  ($signed(pipe_data[2*DATA_WIDTH-1:DATA_WIDTH])),
		.ctl      (ctl_c[0]),
		.cx       (cx_c[0]),
		.cy       (cy_c[0]),
		.z        (z_c[0]),
		.rem      (rem_c[0])
	);

	assign q_c[0] = '0;

	generate
		for (genvar j = 0; j < D; j++) begin : g_cell
			ctp_cordic_cell #(
				.CW    (CW),
				.SHIFT (j),
				.ITERS (NI)
			) u_rot (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.ctl_in  (ctl_c[j]),
				.cx_in   (cx_c[j]),
				.cy_in   (cy_c[j]),
				.z_in    (z_c[j]),
				.ctl_out (ctl_c[j+1]),
				.cx_out  (cx_c[j+1]),
				.cy_out  (cy_c[j+1]),
				.z_out   (z_c[j+1])
			);

			ctp_sqrt_cell #(
				.W   (DATA_WIDTH),
				.RW  (RW),
				.BIT (DATA_WIDTH - 1 - j)
			) u_root (
				.clk     (clk),
				.en      (en),
				.q_in    (q_c[j]),
				.rem_in  (rem_c[j]),
				.q_out   (q_c[j+1]),
				.rem_out (rem_c[j+1])
			);
		end
	endgenerate

	// round q.16 degrees to q8.7, then clamp to +-180
	always_comb begin
		z_rnd = (z_c[D] + ZW'(ROUND_HALF)) >>> ROUND_SHIFT;
		if (z_rnd > ZW'(ANG_DEG_180))
			ang_cordic = ANGLE_WIDTH'(ANG_DEG_180);
		else if (z_rnd < -ZW'(ANG_DEG_180))
			ang_cordic = -ANGLE_WIDTH'(ANG_DEG_180);
		else
			ang_cordic = z_rnd[ANGLE_WIDTH-1:0];

		case (ctl_c[D].sel)
			SEL_CORDIC: ang_nx = ang_cordic;
			SEL_ZERO:   ang_nx = '0;
			SEL_POS180: ang_nx = ANGLE_WIDTH'(ANG_DEG_180);
			SEL_POS90:  ang_nx = ANGLE_WIDTH'(ANG_DEG_90);
			SEL_NEG90:  ang_nx = -ANGLE_WIDTH'(ANG_DEG_90);
			default:    ang_nx = '0;
		endcase

		// remainder above root means the half point is reached
		if (rem_c[D] > RW'(q_c[D]))
			mag_nx = q_c[D] + DATA_WIDTH'(1);
		else
			mag_nx = q_c[D];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_c[D].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= mag_nx;
			ang_q <= ang_nx;
		end
	end

	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[DATA_WIDTH-1:0] = mag_q;
		m_axis_tdata[DATA_WIDTH +: ANGLE_WIDTH] = ang_q;
	end

	a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(!en))
		else $error("skid filled while pipeline advanced");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && en |=> !skid_valid_q)
		else $error("skid item not drained");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ang_q <= ANGLE_WIDTH'(ANG_DEG_180)) &&
			(ang_q >= -ANGLE_WIDTH'(ANG_DEG_180)))
		else $error("angle out of range");

	a_origin_angle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (mag_q == '0) |-> (ang_q == '0))
		else $error("zero magnitude with nonzero angle");

endmodule

`default_nettype wire
